@@ rtl/aglp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aglp_pkg
// Shared types, register codes and fixed-point helpers for the adaptive gain
// law with low-pass block.
// ----------------------------------------------------------------------------
package aglp_pkg;

  localparam int REGRESSORS = 3;
  localparam logic [1:0] K_LAST = 2'(REGRESSORS - 1);

  localparam logic [16:0] ONE_Q16 = 17'd65536;

  localparam logic [2:0] REG_JOINT_COUNT  = 3'd0;
  localparam logic [2:0] REG_ADAPT_GAIN   = 3'd1;
  localparam logic [2:0] REG_LEAK_GAIN    = 3'd2;
  localparam logic [2:0] REG_COEF_LIMIT   = 3'd3;
  localparam logic [2:0] REG_FILTER_GAIN  = 3'd4;

  localparam logic signed [65:0] S32_HI = 66'sh7FFF_FFFF;
  localparam logic signed [65:0] S32_LO = -66'sh8000_0000;
  localparam logic signed [65:0] HALF_Q16 = 66'sd32768;

  typedef struct packed {
    logic [3:0]  joint_count;
    logic [30:0] adapt_gain;
    logic [30:0] leak_gain;
    logic [30:0] coef_limit;
    logic [16:0] filter_gain;
  } cfg_t;

  typedef enum logic [2:0] {
    MS_E_PHI,
    MS_LEAK,
    MS_GRAD,
    MS_T_PHI,
    MS_FA,
    MS_FB
  } mul_sel_t;

  typedef enum logic [2:0] {
    CAP_NONE,
    CAP_M1,
    CAP_LEAK,
    CAP_GRAD,
    CAP_ACC,
    CAP_FSUM
  } cap_t;

  typedef struct packed {
    logic     latch_in;
    logic     rd_coef;
    logic     wr_coef;
    logic     rd_filt;
    logic     wr_filt;
    logic     calc_u;
    logic     load_out;
    logic [1:0] k;
    mul_sel_t mul_sel;
    cap_t     cap;
  } cmd_t;

  typedef struct packed {
    logic in_use;
  } status_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > S32_HI) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < S32_LO) begin
      r = -32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] round_sat(input logic signed [65:0] p);
    logic signed [65:0] s;
    s = (p + HALF_Q16) >>> 16;
    return sat32(s);
  endfunction

endpackage
`default_nettype wire

@@ rtl/adaptive_gain_law_with_lowpass_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adaptive_gain_law_with_lowpass_top
// Per-joint sigma-modification adaptive law with clamped coefficients and a
// first-order low-pass on the command, Q16.16 fixed point.
// ----------------------------------------------------------------------------
// One sample is processed at a time. A joint not in use skips the
// arithmetic and goes straight to the output load. The single shared
// 33x33 multiplier performs fourteen products per sample of a joint in
// use, in sequence; the twelve of the coefficient updates are each
// rounded and saturated on their own, the two low-pass products are
// summed before rounding.
// A new sample is accepted as soon as the previous one has been loaded into
// the output register, even while that result still waits for out_ready.
// Writing joint_count clears all stored coefficients and filter state at
// once through per-joint valid bits; no clearing pass is needed.
module adaptive_gain_law_with_lowpass_top import aglp_pkg::*; #(
  parameter int MAX_JOINTS = 8
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [2:0]         in_joint,
  input  wire logic signed [31:0] in_position,
  input  wire logic signed [31:0] in_velocity,
  input  wire logic signed [31:0] in_reference,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [2:0]              out_joint_out,
  output logic signed [31:0]      out_command,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [30:0]        cfg_data
);

  cfg_t    cfg;
  logic    cfg_clear;
  cmd_t    cmd;
  status_t status;

  aglp_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg),
    .cfg_clear (cfg_clear)
  );

  aglp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  aglp_datapath #(
    .MAX_JOINTS (MAX_JOINTS)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .cfg_clear     (cfg_clear),
    .cmd           (cmd),
    .status        (status),
    .in_joint      (in_joint),
    .in_position   (in_position),
    .in_velocity   (in_velocity),
    .in_reference  (in_reference),
    .out_joint_out (out_joint_out),
    .out_command   (out_command)
  );

endmodule
`default_nettype wire

@@ rtl/aglp_cfg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aglp_cfg
// Configuration register file; a joint_count write raises a state clear.
// ----------------------------------------------------------------------------
module aglp_cfg import aglp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [30:0] cfg_data,
  output cfg_t             cfg,
  output logic             cfg_clear
);

  cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;
  assign cfg_clear = cfg_valid && (cfg_index == REG_JOINT_COUNT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.joint_count <= 4'd1;
      cfg_r.adapt_gain  <= 31'd0;
      cfg_r.leak_gain   <= 31'd0;
      cfg_r.coef_limit  <= 31'h7FFF_FFFF;
      cfg_r.filter_gain <= 17'd32768;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_JOINT_COUNT: cfg_r.joint_count <= cfg_data[3:0];
        REG_ADAPT_GAIN:  cfg_r.adapt_gain  <= cfg_data;
        REG_LEAK_GAIN:   cfg_r.leak_gain   <= cfg_data;
        REG_COEF_LIMIT:  cfg_r.coef_limit  <= cfg_data;
        REG_FILTER_GAIN: cfg_r.filter_gain <= cfg_data[16:0];
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

@@ rtl/aglp_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aglp_ctrl
// Sequencer: steps the shared multiplier through the three coefficient
// updates and the low-pass, and owns the result handshake.
// ----------------------------------------------------------------------------
module aglp_ctrl import aglp_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  input  status_t   status,
  output cmd_t      cmd
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD,
    ST_S1,
    ST_S2,
    ST_S3,
    ST_S4,
    ST_S5,
    ST_S6,
    ST_F0,
    ST_F1,
    ST_F2,
    ST_F3,
    ST_DONE
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] k_r, k_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    cmd         = '0;
    cmd.k       = k_r;
    cmd.mul_sel = MS_E_PHI;
    cmd.cap     = CAP_NONE;
    state_nxt   = state_r;
    k_nxt       = k_r;
    case (state_r)
      ST_IDLE: begin
        cmd.latch_in = in_valid;
        k_nxt        = 2'd0;
        if (in_valid) state_nxt = ST_RD;
      end
      ST_RD: begin
        cmd.rd_coef = 1'b1;
        cmd.mul_sel = MS_E_PHI;
        state_nxt   = status.in_use ? ST_S1 : ST_DONE;
      end
      ST_S1: begin
        cmd.cap     = CAP_M1;
        cmd.mul_sel = MS_LEAK;
        state_nxt   = ST_S2;
      end
      ST_S2: begin
        cmd.cap     = CAP_LEAK;
        cmd.mul_sel = MS_GRAD;
        state_nxt   = ST_S3;
      end
      ST_S3: begin
        cmd.cap   = CAP_GRAD;
        state_nxt = ST_S4;
      end
      ST_S4: begin
        cmd.wr_coef = 1'b1;
        state_nxt   = ST_S5;
      end
      ST_S5: begin
        cmd.mul_sel = MS_T_PHI;
        state_nxt   = ST_S6;
      end
      ST_S6: begin
        cmd.cap = CAP_ACC;
        if (k_r == K_LAST) begin
          state_nxt = ST_F0;
        end else begin
          k_nxt     = k_r + 2'd1;
          state_nxt = ST_RD;
        end
      end
      ST_F0: begin
        cmd.calc_u  = 1'b1;
        cmd.rd_filt = 1'b1;
        state_nxt   = ST_F1;
      end
      ST_F1: begin
        cmd.mul_sel = MS_FA;
        state_nxt   = ST_F2;
      end
      ST_F2: begin
        cmd.cap     = CAP_FSUM;
        cmd.mul_sel = MS_FB;
        state_nxt   = ST_F3;
      end
      ST_F3: begin
        cmd.wr_filt = 1'b1;
        state_nxt   = ST_DONE;
      end
      ST_DONE: begin
        if (slot_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      k_r         <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTH
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while an item is in flight");

  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_valid)
    else $error("result loaded without raising out_valid");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !cmd.load_out)
    else $error("pending result overwritten");

  a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_coef |-> (k_r != 2'd3))
    else $error("coefficient index out of range");
`endif

endmodule
`default_nettype wire

@@ rtl/aglp_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aglp_datapath
// Shared 33x33 multiplier with round/saturate, coefficient and filter
// memories with per-joint valid bits, and the result registers.
// ----------------------------------------------------------------------------
module aglp_datapath import aglp_pkg::*; #(
  parameter int MAX_JOINTS = 8
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  cfg_t                    cfg,
  input  wire logic               cfg_clear,
  input  cmd_t                    cmd,
  output status_t                 status,
  input  wire logic [2:0]         in_joint,
  input  wire logic signed [31:0] in_position,
  input  wire logic signed [31:0] in_velocity,
  input  wire logic signed [31:0] in_reference,
  output logic [2:0]              out_joint_out,
  output logic signed [31:0]      out_command
);

  localparam int CDEPTH = MAX_JOINTS * REGRESSORS;
  localparam int CAW    = (CDEPTH > 1) ? $clog2(CDEPTH) : 1;
  localparam int FAW    = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;

  logic signed [31:0] coef_mem [CDEPTH];
  logic signed [31:0] filt_mem [MAX_JOINTS];
  logic [MAX_JOINTS-1:0] row_valid_r;

  logic [2:0]         joint_r;
  logic signed [31:0] pos_r, vel_r, ref_r, e_r, e_nxt;
  logic signed [31:0] coef_rd_r, filt_rd_r;
  logic signed [65:0] prod_r, prod_nxt, fsum_r;
  logic signed [31:0] m1_r, leak_r, grad_r, t_r, t_nxt, u_r, y_r, y_nxt;
  logic signed [33:0] acc_r;
  logic [2:0]         out_joint_r;
  logic signed [31:0] out_command_r;

  logic [CAW-1:0]     caddr;
  logic [FAW-1:0]     faddr;
  logic [3:0]         jc1;
  logic signed [31:0] theta, y_prev, phi, rs;
  logic signed [32:0] op_a, op_b;
  logic [16:0]        a_eff, a_comp;
  logic signed [33:0] t_full, lim34;

  assign jc1 = (cfg.joint_count == 4'd0) ? 4'd1 : cfg.joint_count;
  assign status.in_use = ({29'd0, joint_r} < 32'(MAX_JOINTS)) && ({1'b0, joint_r} < jc1);

  assign caddr = CAW'({29'd0, joint_r} * 32'(REGRESSORS) + {30'd0, cmd.k});
  assign faddr = FAW'(joint_r);

  assign theta  = row_valid_r[faddr] ? coef_rd_r : 32'sd0;
  assign y_prev = row_valid_r[faddr] ? filt_rd_r : 32'sd0;

  assign a_eff  = (cfg.filter_gain > ONE_Q16) ? ONE_Q16 : cfg.filter_gain;
  assign a_comp = ONE_Q16 - a_eff;

  assign e_nxt = sat32(66'(in_position) - 66'(in_reference));

  always_comb begin
    case (cmd.k)
      2'd0:    phi = pos_r;
      2'd1:    phi = vel_r;
      default: phi = ref_r;
    endcase
  end

  always_comb begin
    case (cmd.mul_sel)
      MS_E_PHI: begin
        op_a = 33'(e_r);
        op_b = 33'(phi);
      end
      MS_LEAK: begin
        op_a = {2'b00, cfg.leak_gain};
        op_b = 33'(theta);
      end
      MS_GRAD: begin
        op_a = {2'b00, cfg.adapt_gain};
        op_b = 33'(m1_r);
      end
      MS_T_PHI: begin
        op_a = 33'(t_r);
        op_b = 33'(phi);
      end
      MS_FA: begin
        op_a = {16'd0, a_eff};
        op_b = 33'(u_r);
      end
      MS_FB: begin
        op_a = {16'd0, a_comp};
        op_b = 33'(y_prev);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign prod_nxt = op_a * op_b;
  assign rs       = round_sat(prod_r);

  assign lim34  = {3'b000, cfg.coef_limit};
  assign t_full = 34'(theta) - 34'(grad_r) - 34'(leak_r);
  always_comb begin
    if (t_full > lim34) begin
      t_nxt = lim34[31:0];
    end else if (t_full < -lim34) begin
      t_nxt = 32'(-lim34);
    end else begin
      t_nxt = t_full[31:0];
    end
  end

  assign y_nxt = round_sat(fsum_r + prod_r);

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (cmd.latch_in) begin
      joint_r <= in_joint;
      pos_r   <= in_position;
      vel_r   <= in_velocity;
      ref_r   <= in_reference;
      e_r     <= e_nxt;
      acc_r   <= 34'sd0;
      y_r     <= 32'sd0;
    end
    case (cmd.cap)
      CAP_M1:   m1_r   <= rs;
      CAP_LEAK: leak_r <= rs;
      CAP_GRAD: grad_r <= rs;
      CAP_ACC:  acc_r  <= acc_r + 34'(rs);
      CAP_FSUM: fsum_r <= prod_r;
      default: begin
      end
    endcase
    if (cmd.wr_coef) t_r <= t_nxt;
    if (cmd.calc_u) u_r <= sat32(66'(acc_r));
    if (cmd.wr_filt) y_r <= y_nxt;
    if (cmd.load_out) begin
      out_joint_r   <= joint_r;
      out_command_r <= y_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_coef) coef_rd_r <= coef_mem[caddr];
    if (cmd.wr_coef) coef_mem[caddr] <= t_nxt;
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_filt) filt_rd_r <= filt_mem[faddr];
    if (cmd.wr_filt) filt_mem[faddr] <= y_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_clear) begin
      row_valid_r <= '0;
    end else if (cmd.wr_filt) begin
      row_valid_r[faddr] <= 1'b1;
    end
  end

  assign out_joint_out = out_joint_r;
  assign out_command   = out_command_r;

endmodule
`default_nettype wire
